FILE: rtl/trsa_pkg.sv
package trsa_pkg;

   // bitmap word geometry
   localparam int unsigned WORD_BITS = 64;
   localparam int unsigned BIT_W     = 6;

   // field widths
   localparam int unsigned SLOT_W     = 11;
   localparam int unsigned IDX_W      = 10;
   localparam int unsigned MODE_W     = 3;
   localparam int unsigned STRIDE_W   = 16;
   localparam int unsigned ADDR_W     = 64;
   localparam int unsigned PROD_W     = STRIDE_W + SLOT_W;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 64;
   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 152;

   // request modes
   localparam logic [MODE_W-1:0] MODE_ALLOC_GEN = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ALLOC_TEX = 3'd1;
   localparam logic [MODE_W-1:0] MODE_FREE      = 3'd2;
   localparam logic [MODE_W-1:0] MODE_COMMIT    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_LOOKUP    = 3'd4;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_SLOT_COUNT    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_TEXTURE_SLOTS = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPLIT_REGIONS = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_HANDLE_STRIDE = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_CPU_BASE      = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_GPU_BASE      = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_GPU_VISIBLE   = 3'd6;

   // register reset values
   localparam logic [SLOT_W-1:0]   RST_SLOT_COUNT    = 11'd1024;
   localparam logic [STRIDE_W-1:0] RST_HANDLE_STRIDE = 16'd32;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_MUL,
      ST_FREE,
      ST_LOOKUP,
      ST_COMMIT,
      ST_RESP
   } state_type;

endpackage

FILE: rtl/two_region_slot_allocator.sv
// Two-region slot allocator.
// Keeps an in-use bitmap and a pending-free bitmap over MAX_SLOTS slots, each held in a
// RAM of 64-bit rows. Slots below the texture boundary form the texture region.
// req channel: one word per command (allocate general, allocate texture, queue free,
//   commit frees, lookup). req_tready is high only while the sequencer is idle.
// rsp channel: exactly one word per command; grant, slot, CPU/GPU address, lookup value.
// csr port: single-cycle writes; user must write only while no command is in flight.
// Steps from accept to rsp_tvalid:
//   allocate: a scan of one 64-slot row per cycle through the shared mask and
//             priority-encode unit, then a multiply step; a scan that finds
//             nothing skips the multiply
//   empty region or unknown mode: no bitmap access; queue free / lookup: one row read
//   commit: one read-modify-write of both bitmaps per row, over all ROWS rows
// Commands are handled one at a time; the next can be accepted in the cycle the
// result turns valid.
// A new command is taken once the result sits in the output register, so a stalled
// receiver holds the block only when a second result is ready to be loaded.
// Reset: control and configuration registers return to their defaults and both
// bitmaps are cleared over ROWS rows (16 at MAX_SLOTS = 1024) while req_tready is low.
// The output register holds its word until rsp_tready is seen.
module two_region_slot_allocator
   import trsa_pkg::*;
#(
   parameter int unsigned MAX_SLOTS = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // commands
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // mode[2:0], slot_index[12:3], zero pad
   // results
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // granted[0], granted_slot[10:1],
                                             // cpu_address[74:11], gpu_address[138:75],
                                             // texture_number[148:139], zero pad
);

   localparam int unsigned ROWS  = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int unsigned CW    = (ROW_W > 5) ? ROW_W + 1 : 6;
   localparam int unsigned CAP   = (MAX_SLOTS > 2047) ? 2047 : MAX_SLOTS;

   // configuration registers
   logic [SLOT_W-1:0]   slot_count_ff;
   logic [SLOT_W-1:0]   texture_slots_ff;
   logic                split_ff;
   logic [STRIDE_W-1:0] stride_ff;
   logic [ADDR_W-1:0]   cpu_base_ff;
   logic [ADDR_W-1:0]   gpu_base_ff;
   logic                gpu_visible_ff;

   // sequencer
   state_type         state_ff, state_in;
   logic [CW-1:0]     chk_row_ff, chk_row_in;
   logic [SLOT_W-1:0] lo_ff, lo_in;
   logic [SLOT_W-1:0] hi_m1_ff, hi_m1_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              res_granted_ff, res_granted_in;
   logic [IDX_W-1:0]  res_tex_ff, res_tex_in;

   // output register
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic              rsp_granted_ff, rsp_granted_in;
   logic [IDX_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [ADDR_W-1:0] rsp_cpu_ff, rsp_cpu_in;
   logic [ADDR_W-1:0] rsp_gpu_ff, rsp_gpu_in;
   logic [IDX_W-1:0]  rsp_tex_ff, rsp_tex_in;

   // bitmap RAM ports
   logic                 inuse_we, pend_we;
   logic [ROW_W-1:0]     inuse_wa, pend_wa, rd_addr;
   logic [WORD_BITS-1:0] inuse_wd, pend_wd, inuse_rd, pend_rd;
   logic [CW-1:0]        rd_row;

   // decode
   logic [MODE_W-1:0] req_mode;
   logic [IDX_W-1:0]  req_idx;
   logic [SLOT_W-1:0] count_eff, bound_eff, acc_lo, acc_hi;
   logic [CW-1:0]     start_row, first_row, last_row;
   logic [WORD_BITS-1:0] row_mask, free_bits;
   logic [BIT_W-1:0]  hit_pos;

   function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
      logic [BIT_W-1:0] pos;
      pos = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            pos = BIT_W'(i);
         end
      end
      return pos;
   endfunction

   assign req_mode = req_tdata[MODE_W-1:0];
   assign req_idx  = req_tdata[MODE_W+IDX_W-1:MODE_W];

   // clamp count to storage, boundary to count
   assign count_eff = (slot_count_ff > SLOT_W'(CAP)) ? SLOT_W'(CAP) : slot_count_ff;
   assign bound_eff = (texture_slots_ff > count_eff) ? count_eff : texture_slots_ff;

   // search window of an allocation: [acc_lo, acc_hi)
   assign acc_lo = (req_mode == MODE_ALLOC_GEN && split_ff) ? bound_eff : '0;
   assign acc_hi = (req_mode == MODE_ALLOC_GEN) ? count_eff : bound_eff;

   always_comb begin
      case (req_mode)
         MODE_ALLOC_GEN, MODE_ALLOC_TEX: start_row = CW'(acc_lo[SLOT_W-1:BIT_W]);
         MODE_FREE, MODE_LOOKUP:         start_row = CW'(req_idx[IDX_W-1:BIT_W]);
         default:                        start_row = '0;
      endcase
   end

   assign first_row = CW'(lo_ff[SLOT_W-1:BIT_W]);
   assign last_row  = CW'(hi_m1_ff[SLOT_W-1:BIT_W]);

   // window edges trimmed inside the first and last rows
   always_comb begin
      row_mask = '1;
      if (chk_row_ff == first_row) begin
         row_mask = row_mask & (WORD_BITS'('1) << lo_ff[BIT_W-1:0]);
      end
      if (chk_row_ff == last_row) begin
         row_mask = row_mask
            & (WORD_BITS'('1) >> (BIT_W'(WORD_BITS - 1) - hi_m1_ff[BIT_W-1:0]));
      end
   end

   assign free_bits = ~inuse_rd & row_mask;
   assign hit_pos   = lowest_set(free_bits);

   // read issue: start row at accept, next row while sweeping
   always_comb begin
      case (state_ff)
         ST_IDLE:                      rd_row = start_row;
         ST_SCAN, ST_COMMIT, ST_CLEAR: rd_row = chk_row_ff + CW'(1);
         default:                      rd_row = chk_row_ff;
      endcase
   end
   assign rd_addr = rd_row[ROW_W-1:0];

   always_comb begin
      state_in       = state_ff;
      chk_row_in     = chk_row_ff;
      lo_in          = lo_ff;
      hi_m1_in       = hi_m1_ff;
      idx_in         = idx_ff;
      slot_in        = slot_ff;
      prod_in        = prod_ff;
      res_granted_in = res_granted_ff;
      res_tex_in     = res_tex_ff;
      rsp_tvalid_in  = rsp_tvalid_ff && !rsp_tready;
      rsp_granted_in = rsp_granted_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_cpu_in     = rsp_cpu_ff;
      rsp_gpu_in     = rsp_gpu_ff;
      rsp_tex_in     = rsp_tex_ff;
      inuse_we       = 1'b0;
      inuse_wa       = chk_row_ff[ROW_W-1:0];
      inuse_wd       = '0;
      pend_we        = 1'b0;
      pend_wa        = chk_row_ff[ROW_W-1:0];
      pend_wd        = '0;

      case (state_ff)
         ST_CLEAR: begin
            inuse_we   = 1'b1;
            pend_we    = 1'b1;
            chk_row_in = chk_row_ff + CW'(1);
            if (chk_row_ff == CW'(ROWS - 1)) begin
               chk_row_in = '0;
               state_in   = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               idx_in         = req_idx;
               lo_in          = acc_lo;
               hi_m1_in       = acc_hi - SLOT_W'(1);
               chk_row_in     = start_row;
               slot_in        = '0;
               res_granted_in = 1'b0;
               res_tex_in     = '0;
               case (req_mode)
                  MODE_ALLOC_GEN, MODE_ALLOC_TEX: begin
                     state_in = (acc_lo < acc_hi) ? ST_SCAN : ST_RESP;
                  end
                  MODE_FREE:   state_in = ST_FREE;
                  MODE_COMMIT: state_in = ST_COMMIT;
                  MODE_LOOKUP: state_in = ST_LOOKUP;
                  default:     state_in = ST_RESP;
               endcase
            end
         end
         ST_SCAN: begin
            if (|free_bits) begin
               inuse_we       = 1'b1;
               inuse_wd       = inuse_rd | (WORD_BITS'(1) << hit_pos);
               slot_in        = {chk_row_ff[SLOT_W-BIT_W-1:0], hit_pos};
               res_granted_in = 1'b1;
               state_in       = ST_MUL;
            end else if (chk_row_ff == last_row) begin
               state_in = ST_RESP;
            end else begin
               chk_row_in = chk_row_ff + CW'(1);
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(stride_ff) * PROD_W'(slot_ff);
            state_in = ST_RESP;
         end
         ST_FREE: begin
            if (32'(idx_ff) < 32'(MAX_SLOTS)) begin
               pend_we = 1'b1;
               pend_wa = ROW_W'(idx_ff[IDX_W-1:BIT_W]);
               pend_wd = pend_rd | (WORD_BITS'(1) << idx_ff[BIT_W-1:0]);
            end
            state_in = ST_RESP;
         end
         ST_LOOKUP: begin
            if ((SLOT_W'(idx_ff) < bound_eff) && inuse_rd[idx_ff[BIT_W-1:0]]) begin
               res_tex_in = idx_ff;
            end else begin
               res_tex_in = IDX_W'(1);
            end
            state_in = ST_RESP;
         end
         ST_COMMIT: begin
            inuse_we   = 1'b1;
            inuse_wd   = inuse_rd & ~pend_rd;
            pend_we    = 1'b1;
            chk_row_in = chk_row_ff + CW'(1);
            if (chk_row_ff == CW'(ROWS - 1)) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            // load once the output register is free or being drained
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in  = 1'b1;
               rsp_granted_in = res_granted_ff;
               rsp_slot_in    = slot_ff[IDX_W-1:0];
               rsp_cpu_in     = res_granted_ff ? cpu_base_ff + ADDR_W'(prod_ff) : '0;
               rsp_gpu_in     = (res_granted_ff && gpu_visible_ff)
                                ? gpu_base_ff + ADDR_W'(prod_ff) : '0;
               rsp_tex_in     = res_tex_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         chk_row_ff       <= '0;
         rsp_tvalid_ff    <= 1'b0;
         slot_count_ff    <= RST_SLOT_COUNT;
         texture_slots_ff <= '0;
         split_ff         <= 1'b0;
         stride_ff        <= RST_HANDLE_STRIDE;
         cpu_base_ff      <= '0;
         gpu_base_ff      <= '0;
         gpu_visible_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         chk_row_ff    <= chk_row_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_we) begin
            case (csr_addr)
               CSR_SLOT_COUNT:    slot_count_ff    <= csr_wdata[SLOT_W-1:0];
               CSR_TEXTURE_SLOTS: texture_slots_ff <= csr_wdata[SLOT_W-1:0];
               CSR_SPLIT_REGIONS: split_ff         <= csr_wdata[0];
               CSR_HANDLE_STRIDE: stride_ff        <= csr_wdata[STRIDE_W-1:0];
               CSR_CPU_BASE:      cpu_base_ff      <= csr_wdata;
               CSR_GPU_BASE:      gpu_base_ff      <= csr_wdata;
               CSR_GPU_VISIBLE:   gpu_visible_ff   <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      lo_ff          <= lo_in;
      hi_m1_ff       <= hi_m1_in;
      idx_ff         <= idx_in;
      slot_ff        <= slot_in;
      prod_ff        <= prod_in;
      res_granted_ff <= res_granted_in;
      res_tex_ff     <= res_tex_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_cpu_ff     <= rsp_cpu_in;
      rsp_gpu_ff     <= rsp_gpu_in;
      rsp_tex_ff     <= rsp_tex_in;
   end

   trsa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (ROWS)
   ) u_inuse_ram (
      .clock   (clock),
      .wr_en   (inuse_we),
      .wr_addr (inuse_wa),
      .wr_data (inuse_wd),
      .rd_addr (rd_addr),
      .rd_data (inuse_rd)
   );

   trsa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (ROWS)
   ) u_pend_ram (
      .clock   (clock),
      .wr_en   (pend_we),
      .wr_addr (pend_wa),
      .wr_data (pend_wd),
      .rd_addr (rd_addr),
      .rd_data (pend_rd)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {3'b000, rsp_tex_ff, rsp_gpu_ff, rsp_cpu_ff, rsp_slot_ff,
                        rsp_granted_ff};

`ifndef SYNTHESIS
   // bitmap untouched between commands
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!inuse_we && !pend_we))
      else $error("bitmap written while idle");

   // no command taken during the clearing pass
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready)
      else $error("command accepted during clear");

   // scan never runs past the window
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (chk_row_ff <= last_row))
      else $error("scan beyond last row");

   // granted slot lies inside the search window
   a_grant_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (slot_ff >= lo_ff && slot_ff <= hi_m1_ff && res_granted_ff))
      else $error("grant outside window");

   // a new result only comes from the response state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == ST_RESP))
      else $error("result raised outside response state");
`endif

endmodule

FILE: rtl/trsa_ram.sv
module trsa_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import trsa_pkg::*;

   localparam int unsigned SLOTS       = 1024;
   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned HOLD_AFTER  = 300;   // words accepted before the long hold
   localparam int unsigned MAX_WAIT    = 18;
   localparam int unsigned DRAIN_WAIT  = 40;    // longer than any single command
   // modes with no meaning: the block must answer with an all-zero word
   localparam logic [MODE_W-1:0] MODE_BAD_FIRST = 3'd5;
   localparam logic [MODE_W-1:0] MODE_BAD_LAST  = 3'd7;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [IDX_W-1:0]  idx;
   } command_type;

   typedef struct packed {
      logic              granted;
      logic [IDX_W-1:0]  slot;
      logic [ADDR_W-1:0] cpu;
      logic [ADDR_W-1:0] gpu;
      logic [IDX_W-1:0]  tex;
   } reply_type;

   // DUT inputs start at known values
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // shadow registers, same reset values as the block
   logic [SLOT_W-1:0]   cfg_slot_count    = RST_SLOT_COUNT;
   logic [SLOT_W-1:0]   cfg_texture_slots = '0;
   logic                cfg_split         = 1'b0;
   logic [STRIDE_W-1:0] cfg_stride        = RST_HANDLE_STRIDE;
   logic [ADDR_W-1:0]   cfg_cpu_base      = '0;
   logic [ADDR_W-1:0]   cfg_gpu_base      = '0;
   logic                cfg_gpu_visible   = 1'b0;

   // shadow bitmaps
   logic [SLOTS-1:0] slot_busy = '0;
   logic [SLOTS-1:0] free_mark = '0;

   command_type cmd_backlog[$];    // commands not yet offered
   reply_type   owed_replies[$];   // predicted words, oldest first

   int unsigned cycle_count    = 0;
   int unsigned accepted_items = 0;
   int unsigned checked_words  = 0;
   int unsigned mismatches     = 0;
   int unsigned settings_used  = 0;
   int unsigned grant_count    = 0;
   int unsigned refusal_count  = 0;
   int unsigned lookup_hits    = 0;
   int unsigned commit_count   = 0;
   int unsigned req_wait       = 0;
   int unsigned rsp_wait       = 0;
   int unsigned req_calm       = 0;
   int unsigned rsp_calm       = 0;
   int unsigned hold_count     = 0;
   logic        rsp_hold       = 1'b0;
   logic        hold_done      = 1'b0;

   two_region_slot_allocator #(
      .MAX_SLOTS (SLOTS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // mode[2:0], slot_index[12:3], zero pad
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)    // granted[0], granted_slot[10:1], cpu_address[74:11],
                                 // gpu_address[138:75], texture_number[148:139], zero pad
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Allocator behavior, applied once per accepted command word.
   // Updates the shadow bitmaps and returns the word the block owes.
   // ------------------------------------------------------------------
   function automatic int unsigned live_slots();
      return (cfg_slot_count > SLOTS) ? SLOTS : cfg_slot_count;
   endfunction

   function automatic reply_type allocator_reply(logic [MODE_W-1:0] mode,
                                                 logic [IDX_W-1:0] idx);
      int unsigned       cnt;
      int unsigned       bnd;
      int unsigned       lo;
      int unsigned       hi;
      int unsigned       pick;
      logic [ADDR_W-1:0] offset;
      reply_type         r;
      r   = '0;
      cnt = live_slots();
      // boundary is clamped to the live slot count
      bnd = (cfg_texture_slots > cnt) ? cnt : cfg_texture_slots;
      case (mode)
         MODE_ALLOC_GEN, MODE_ALLOC_TEX: begin
            if (mode == MODE_ALLOC_GEN) begin
               lo = cfg_split ? bnd : 0;
               hi = cnt;
            end else begin
               lo = 0;
               hi = bnd;
            end
            // first fit: lowest free slot in [lo, hi)
            pick = hi;
            for (int unsigned i = lo; i < hi && pick == hi; i++) begin
               if (!slot_busy[i]) pick = i;
            end
            if (pick < hi) begin
               slot_busy[pick] = 1'b1;
               offset    = ADDR_W'(pick) * ADDR_W'(cfg_stride);
               r.granted = 1'b1;
               r.slot    = pick[IDX_W-1:0];
               r.cpu     = cfg_cpu_base + offset;
               r.gpu     = cfg_gpu_visible ? cfg_gpu_base + offset : '0;
               grant_count++;
            end else begin
               refusal_count++;
            end
         end
         MODE_FREE: begin
            // only marked; slot stays taken until a commit
            free_mark[idx] = 1'b1;
         end
         MODE_COMMIT: begin
            slot_busy = slot_busy & ~free_mark;
            free_mark = '0;
            commit_count++;
         end
         MODE_LOOKUP: begin
            if (idx < bnd && slot_busy[idx]) begin
               r.tex = idx;
               lookup_hits++;
            end else begin
               r.tex = IDX_W'(1);
            end
         end
         default: ;   // unknown mode: no state change, all-zero word
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Configuration, only called while nothing is in flight
   // ------------------------------------------------------------------
   task automatic write_csr(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_SLOT_COUNT:    cfg_slot_count    = val[SLOT_W-1:0];
         CSR_TEXTURE_SLOTS: cfg_texture_slots = val[SLOT_W-1:0];
         CSR_SPLIT_REGIONS: cfg_split         = val[0];
         CSR_HANDLE_STRIDE: cfg_stride        = val[STRIDE_W-1:0];
         CSR_CPU_BASE:      cfg_cpu_base      = val;
         CSR_GPU_BASE:      cfg_gpu_base      = val;
         CSR_GPU_VISIBLE:   cfg_gpu_visible   = val[0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(logic [SLOT_W-1:0] count, logic [SLOT_W-1:0] tex,
                                 logic split, logic [STRIDE_W-1:0] stride,
                                 logic [ADDR_W-1:0] cpu, logic [ADDR_W-1:0] gpu,
                                 logic vis);
      write_csr(CSR_SLOT_COUNT, CSR_DATA_W'(count));
      write_csr(CSR_TEXTURE_SLOTS, CSR_DATA_W'(tex));
      write_csr(CSR_SPLIT_REGIONS, CSR_DATA_W'(split));
      write_csr(CSR_HANDLE_STRIDE, CSR_DATA_W'(stride));
      write_csr(CSR_CPU_BASE, cpu);
      write_csr(CSR_GPU_BASE, gpu);
      write_csr(CSR_GPU_VISIBLE, CSR_DATA_W'(vis));
      settings_used++;
   endtask

   task automatic add_cmd(logic [MODE_W-1:0] mode, logic [IDX_W-1:0] idx);
      command_type c;
      c.mode = mode;
      c.idx  = idx;
      cmd_backlog.insert(cmd_backlog.size(), c);
   endtask

   // Random mix weighted toward allocate/free/commit cycles so the bitmap
   // fills, drains and gets reused; indexes mostly land near the live slots.
   task automatic add_random(int unsigned n);
      int unsigned       roll;
      int unsigned       span;
      logic [MODE_W-1:0] mode;
      logic [IDX_W-1:0]  idx;
      span = (live_slots() <= 64) ? live_slots() + 3 : 127;
      for (int unsigned k = 0; k < n; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < 30)      mode = MODE_ALLOC_GEN;
         else if (roll < 55) mode = MODE_ALLOC_TEX;
         else if (roll < 73) mode = MODE_FREE;
         else if (roll < 80) mode = MODE_COMMIT;
         else if (roll < 97) mode = MODE_LOOKUP;
         else                mode = MODE_W'($urandom_range(MODE_BAD_FIRST, MODE_BAD_LAST));
         if ($urandom_range(0, 4) == 0) idx = IDX_W'($urandom_range(0, SLOTS - 1));
         else                           idx = IDX_W'($urandom_range(0, span));
         add_cmd(mode, idx);
      end
   endtask

   // sampled on the falling edge so nothing races the driver or monitor
   task automatic wait_drained();
      do @(negedge clock);
      while (cmd_backlog.size() != 0 || req_tvalid || owed_replies.size() != 0);
   endtask

   task automatic run_random_phase(logic [SLOT_W-1:0] count, logic [SLOT_W-1:0] tex,
                                   logic split, logic [STRIDE_W-1:0] stride,
                                   logic [ADDR_W-1:0] cpu, logic [ADDR_W-1:0] gpu,
                                   logic vis, int unsigned n);
      apply_settings(count, tex, split, stride, cpu, gpu, vis);
      add_random(n);
      wait_drained();
   endtask

   // ------------------------------------------------------------------
   // Sequence of phases
   // ------------------------------------------------------------------
   initial begin : stimulus
      logic [SLOT_W-1:0] cnt;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // bitmap clearing pass: tready comes up when it is done
      do @(negedge clock);
      while (!req_tready);

      // Directed: 4 slots, 2 texture, split on, extreme stride and bases
      apply_settings(11'd4, 11'd2, 1'b1, '1, '1, 64'h8000_0000_0000_0000, 1'b1);
      add_cmd(MODE_ALLOC_TEX, '0);
      add_cmd(MODE_ALLOC_TEX, '0);
      add_cmd(MODE_ALLOC_TEX, '0);   // texture region exhausted
      add_cmd(MODE_ALLOC_GEN, '1);
      add_cmd(MODE_ALLOC_GEN, '0);
      add_cmd(MODE_ALLOC_GEN, '0);   // general region exhausted
      add_cmd(MODE_LOOKUP, 10'd0);
      add_cmd(MODE_LOOKUP, 10'd1);
      add_cmd(MODE_LOOKUP, 10'd2);   // above boundary
      add_cmd(MODE_LOOKUP, '1);
      add_cmd(MODE_FREE, 10'd0);
      add_cmd(MODE_FREE, 10'd0);     // repeated free
      add_cmd(MODE_ALLOC_TEX, '0);   // pending slot not reused yet
      add_cmd(MODE_FREE, 10'd3);
      add_cmd(MODE_FREE, '1);        // slot outside the live count, never taken
      add_cmd(MODE_COMMIT, '0);
      add_cmd(MODE_LOOKUP, 10'd0);
      add_cmd(MODE_ALLOC_TEX, '0);
      add_cmd(MODE_ALLOC_GEN, '0);
      add_cmd(MODE_BAD_FIRST, '1);
      add_cmd(MODE_BAD_FIRST + 3'd1, 10'h2AA);
      add_cmd(MODE_BAD_LAST, 10'h155);
      add_cmd(MODE_LOOKUP, 10'd3);
      wait_drained();

      // small heap: constant exhaustion and reuse
      run_random_phase(11'd40, 11'd12, 1'b1, 16'($urandom), {$urandom, $urandom},
                       {$urandom, $urandom}, 1'b1, 200);
      // oversized count and boundary: general region empty when split
      run_random_phase('1, '1, 1'b1, '1, '1, '1, 1'b1, 150);
      // zero slot count: nothing can be granted
      run_random_phase('0, 11'd5, 1'($urandom), 16'($urandom), {$urandom, $urandom},
                       {$urandom, $urandom}, 1'b1, 60);
      // single slot, zero stride, GPU addresses off
      run_random_phase(11'd1, '0, 1'b0, '0, {$urandom, $urandom}, {$urandom, $urandom},
                       1'b0, 100);
      // full heap with a large texture region, long scans
      run_random_phase(11'd1024, 11'd300, 1'b0, 16'($urandom), '0, '1, 1'b1, 250);
      // shrunk count: higher slots keep their bits but are out of reach
      run_random_phase(11'd16, 11'd16, 1'b1, 16'($urandom), {$urandom, $urandom},
                       {$urandom, $urandom}, 1'($urandom), 200);
      repeat (3) begin
         cnt = SLOT_W'($urandom_range(1, 96));
         run_random_phase(cnt, SLOT_W'($urandom_range(0, cnt + 8)), 1'($urandom),
                          16'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                          1'($urandom), 200);
      end

      // let any stray word show up before the verdict
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("Checked %0d result words over %0d register settings.",
               checked_words, settings_used);
      $display("Saw %0d grants, %0d refused allocations, %0d lookup hits, %0d commits.",
               grant_count, refusal_count, lookup_hits, commit_count);
      if (mismatches == 0 && owed_replies.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // Command driver: one word per handshake, random gap after each word.
   // A word with no gap keeps tvalid high into the next one.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : cmd_driver
      logic        slot_open;
      int unsigned gap;
      command_type c;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_wait   <= 0;
         req_calm   <= 0;
      end else begin
         slot_open = !req_tvalid || req_tready;
         gap       = req_wait;
         if (req_tvalid && req_tready) begin
            owed_replies.insert(owed_replies.size(),
                                allocator_reply(req_tdata[MODE_W-1:0],
                                                req_tdata[MODE_W +: IDX_W]));
            accepted_items <= accepted_items + 1;
            // occasional bursts with no gaps at all
            if (req_calm > 0) begin
               req_calm <= req_calm - 1;
               gap = 0;
            end else begin
               if ($urandom_range(0, 49) == 0) req_calm <= 40;
               gap = $urandom_range(0, MAX_WAIT);
            end
         end
         if (slot_open) begin
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               req_wait   <= gap - 1;
            end else if (cmd_backlog.size() > 0) begin
               c = cmd_backlog.pop_front();
               req_tdata  <= REQ_DATA_W'({c.idx, c.mode});
               req_tvalid <= 1'b1;
               req_wait   <= 0;
            end else begin
               req_tvalid <= 1'b0;
               req_wait   <= 0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Result monitor: checks every word against the oldest prediction,
   // then stalls tready for a random count of cycles.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      int unsigned stall;
      reply_type   want;
      reply_type   got;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait   <= 0;
         rsp_calm   <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.granted = rsp_tdata[0];
            got.slot    = rsp_tdata[10:1];
            got.cpu     = rsp_tdata[74:11];
            got.gpu     = rsp_tdata[138:75];
            got.tex     = rsp_tdata[148:139];
            checked_words <= checked_words + 1;
            if (owed_replies.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("ERROR: unexpected result word %h at cycle %0d", got, cycle_count);
            end else begin
               want = owed_replies.pop_front();
               if (got.granted !== want.granted || got.slot !== want.slot ||
                   got.cpu !== want.cpu || got.gpu !== want.gpu || got.tex !== want.tex)
               begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10) begin
                     $display("ERROR: word %0d at cycle %0d", checked_words, cycle_count);
                     $display("  granted  exp %0d got %0d", want.granted, got.granted);
                     $display("  slot     exp %0d got %0d", want.slot, got.slot);
                     $display("  cpu      exp %h got %h", want.cpu, got.cpu);
                     $display("  gpu      exp %h got %h", want.gpu, got.gpu);
                     $display("  tex num  exp %0d got %0d", want.tex, got.tex);
                  end
               end
            end
            if (rsp_calm > 0) begin
               rsp_calm <= rsp_calm - 1;
               stall = 0;
            end else begin
               if ($urandom_range(0, 49) == 0) rsp_calm <= 40;
               stall = $urandom_range(0, MAX_WAIT);
            end
            rsp_wait   <= stall;
            rsp_tready <= (stall == 0) && !rsp_hold;
         end else if (rsp_wait > 0) begin
            rsp_wait   <= rsp_wait - 1;
            rsp_tready <= (rsp_wait == 1) && !rsp_hold;
         end else begin
            rsp_tready <= !rsp_hold;
         end
      end
   end

   // One long receiver hold mid-run while commands keep coming, so the
   // output register and the sequencer both fill and req_tready drops.
   always @(posedge clock) begin : long_hold
      if (reset) begin
         rsp_hold   <= 1'b0;
         hold_done  <= 1'b0;
         hold_count <= 0;
      end else if (!hold_done && !rsp_hold && accepted_items >= HOLD_AFTER) begin
         rsp_hold   <= 1'b1;
         hold_count <= 0;
      end else if (rsp_hold) begin
         hold_count <= hold_count + 1;
         if (hold_count == HOLD_CYCLES) begin
            rsp_hold  <= 1'b0;
            hold_done <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d words still owed",
                  cycle_count, owed_replies.size());
         $display("Some tests failed");
         $finish;
      end
   end

endmodule
